// ===== rtl/wsm_pkg.sv =====
package wsm_pkg;

  localparam int unsigned MaxPatternLen = 64;
  localparam int unsigned MaxNameLen    = 256;

  localparam logic [7:0] StarChar = 8'h2A;
  localparam logic [7:0] DotChar  = 8'h2E;

  localparam logic KindPattern = 1'b0;
  localparam logic KindName    = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StFetch0,
    StDot,
    StFetch,
    StStep,
    StDone
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_value;
    logic       last;
  } in_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } out_t;

endpackage

// ===== rtl/wildcard_star_matcher.sv =====
// Channel  Direction  Payload         Flow control
// in       input      wsm_pkg::in_t   in_valid_i / in_stall_o
// out      output     wsm_pkg::out_t  out_valid_o / out_stall_i
//
// Pattern and name bytes are taken one per cycle while the block is idle.
// After the last name byte the walk does its setup (first read, dot check), then the
// steps of one shared compare unit; each step after the first is a memory read of both
// stores, then the compare. A name of N bytes against a pattern of P bytes needs at
// most about N * (P + 1) + P steps. An overflow skips the walk.
// The result waits in an output register while no input is taken. Reset clears the
// lengths, overflow flags and the sequencer.
module wildcard_star_matcher #(
  parameter int unsigned MAX_PATTERN_LEN = wsm_pkg::MaxPatternLen,
  parameter int unsigned MAX_NAME_LEN    = wsm_pkg::MaxNameLen
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wsm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wsm_pkg::out_t out_data_o
);

  localparam int unsigned PlW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned PaW = $clog2(MAX_PATTERN_LEN);
  localparam int unsigned NlW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned NaW = $clog2(MAX_NAME_LEN);

  wsm_pkg::state_e state_q, state_d;

  logic [7:0] pat_mem  [MAX_PATTERN_LEN];
  logic [7:0] name_mem [MAX_NAME_LEN];
  logic [7:0] rp_q, rn_q;

  logic [PlW-1:0] plen_q, plen_d;
  logic           povf_q, povf_d;
  logic           pdone_q, pdone_d;
  logic [NlW-1:0] nlen_q, nlen_d;
  logic           novf_q, novf_d;
  logic [PlW-1:0] pp_q, pp_d;
  logic [NlW-1:0] np_q, np_d;
  logic [PaW-1:0] sp_q, sp_d;
  logic           sv_q, sv_d;
  logic [NlW-1:0] rs_q, rs_d;
  wsm_pkg::out_t  res_q, res_d;

  logic           in_xfer, out_xfer;
  logic           pwe, nwe;
  logic [PaW-1:0] pwaddr;
  logic [NaW-1:0] nwaddr;
  logic [PlW-1:0] pbase;
  logic           novf_new;
  logic           have_p, np_lt, p_star, p_eq, dot_fail;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  assign pbase    = pdone_q ? '0 : plen_q;
  assign novf_new = novf_q || (nlen_q >= NlW'(MAX_NAME_LEN));

  // Shared compare unit for one walk step.
  assign have_p   = pp_q < plen_q;
  assign np_lt    = np_q < nlen_q;
  assign p_star   = rp_q == wsm_pkg::StarChar;
  assign p_eq     = rp_q == rn_q;
  assign dot_fail = (nlen_q != '0) && (rn_q == wsm_pkg::DotChar) &&
                    ((plen_q == '0) || (rp_q != wsm_pkg::DotChar));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wsm_pkg::StIdle: begin
        if (in_xfer && in_data_i.kind == wsm_pkg::KindName && in_data_i.last) begin
          state_d = (povf_q || novf_new) ? wsm_pkg::StDone : wsm_pkg::StFetch0;
        end
      end
      wsm_pkg::StFetch0: state_d = wsm_pkg::StDot;
      wsm_pkg::StDot:    state_d = dot_fail ? wsm_pkg::StDone : wsm_pkg::StStep;
      wsm_pkg::StFetch:  state_d = wsm_pkg::StStep;
      wsm_pkg::StStep: begin
        if (np_lt) begin
          if ((have_p && (p_star || p_eq)) || sv_q) begin
            state_d = wsm_pkg::StFetch;
          end else begin
            state_d = wsm_pkg::StDone;
          end
        end else if (have_p && p_star) begin
          state_d = wsm_pkg::StFetch;
        end else begin
          state_d = wsm_pkg::StDone;
        end
      end
      wsm_pkg::StDone: begin
        if (!out_stall_i) begin
          state_d = wsm_pkg::StIdle;
        end
      end
      default: state_d = wsm_pkg::StIdle;
    endcase
  end

  // Datapath updates.
  always_comb begin
    plen_d  = plen_q;
    povf_d  = povf_q;
    pdone_d = pdone_q;
    nlen_d  = nlen_q;
    novf_d  = novf_q;
    pp_d    = pp_q;
    np_d    = np_q;
    sp_d    = sp_q;
    sv_d    = sv_q;
    rs_d    = rs_q;
    res_d   = res_q;
    pwe     = 1'b0;
    nwe     = 1'b0;
    pwaddr  = pbase[PaW-1:0];
    nwaddr  = nlen_q[NaW-1:0];
    case (state_q)
      wsm_pkg::StIdle: begin
        if (in_xfer) begin
          if (in_data_i.kind == wsm_pkg::KindPattern) begin
            pdone_d = in_data_i.last;
            if (pbase < PlW'(MAX_PATTERN_LEN)) begin
              pwe    = 1'b1;
              plen_d = pbase + PlW'(1);
              povf_d = pdone_q ? 1'b0 : povf_q;
            end else begin
              plen_d = pbase;
              povf_d = 1'b1;
            end
          end else begin
            if (nlen_q < NlW'(MAX_NAME_LEN)) begin
              nwe    = 1'b1;
              nlen_d = nlen_q + NlW'(1);
            end else begin
              novf_d = 1'b1;
            end
            pp_d = '0;
            np_d = '0;
            sv_d = 1'b0;
            rs_d = '0;
            res_d.matched  = 1'b0;
            res_d.too_long = povf_q || novf_new;
          end
        end
      end
      wsm_pkg::StDot: begin
        res_d.matched = 1'b0;
      end
      wsm_pkg::StStep: begin
        if (np_lt) begin
          if (have_p && p_star) begin
            sp_d = pp_q[PaW-1:0];
            sv_d = 1'b1;
            pp_d = pp_q + PlW'(1);
            rs_d = np_q;
          end else if (have_p && p_eq) begin
            pp_d = pp_q + PlW'(1);
            np_d = np_q + NlW'(1);
          end else if (sv_q) begin
            pp_d = PlW'(sp_q) + PlW'(1);
            rs_d = rs_q + NlW'(1);
            np_d = rs_q + NlW'(1);
          end else begin
            res_d.matched = 1'b0;
          end
        end else if (have_p && p_star) begin
          pp_d = pp_q + PlW'(1);
        end else begin
          res_d.matched = pp_q == plen_q;
        end
      end
      wsm_pkg::StDone: begin
        if (out_xfer) begin
          nlen_d = '0;
          novf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  assign in_stall_o  = state_q != wsm_pkg::StIdle;
  assign out_valid_o = state_q == wsm_pkg::StDone;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pat_mem[pwaddr] <= in_data_i.char_value;
    end
    rp_q <= pat_mem[pp_q[PaW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      name_mem[nwaddr] <= in_data_i.char_value;
    end
    rn_q <= name_mem[np_q[NaW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsm_pkg::StIdle;
      plen_q  <= '0;
      povf_q  <= 1'b0;
      pdone_q <= 1'b1;
      nlen_q  <= '0;
      novf_q  <= 1'b0;
      pp_q    <= '0;
      np_q    <= '0;
      sp_q    <= '0;
      sv_q    <= 1'b0;
      rs_q    <= '0;
    end else begin
      state_q <= state_d;
      plen_q  <= plen_d;
      povf_q  <= povf_d;
      pdone_q <= pdone_d;
      nlen_q  <= nlen_d;
      novf_q  <= novf_d;
      pp_q    <= pp_d;
      np_q    <= np_d;
      sp_q    <= sp_d;
      sv_q    <= sv_d;
      rs_q    <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== rtl/wsm_checker.sv =====
module wsm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input wsm_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input wsm_pkg::out_t out_data_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // No input transfer while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // The last byte of a name starts a walk or a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind == wsm_pkg::KindName && in_data_i.last
    |=> in_stall_o)
    else $error("name end did not start a match");

  // An overflowed string never reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_long |-> !out_data_o.matched)
    else $error("match reported with too_long");

endmodule

bind wildcard_star_matcher wsm_checker u_wsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam wsm_pkg::out_t Miss      = '{matched: 1'b0, too_long: 1'b0};
  localparam wsm_pkg::out_t OverLimit = '{matched: 1'b0, too_long: 1'b1};
  localparam int   NumRows   = 27;
  localparam int   RandBytes = 1040;

  typedef struct {
    logic          kind;
    string         pre;
    logic [7:0]    fill;
    int            nfill;
    string         post;
    bit            open;
    bit            pinned;
    wsm_pkg::out_t verdict;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  wsm_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  wsm_pkg::out_t out_data_o;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int mismatches = 0;

  wsm_pkg::out_t expected_verdicts[$];

  // Shadow copy of the pattern and name stores.
  bit [7:0] pat_mem [wsm_pkg::MaxPatternLen];
  int       pat_len = 0;
  bit       pat_ovf = 1'b0;
  bit       pat_done = 1'b1;
  bit [7:0] name_mem [wsm_pkg::MaxNameLen];
  int       name_len = 0;
  bit       name_ovf = 1'b0;

  // Rows hold a string as prefix, a repeated fill byte and a suffix.
  dir_row_t dir_rows [0:NumRows-1] = '{
    '{wsm_pkg::KindName,    "abc",     8'h00, 0,   "",    1'b0, 1'b1, Miss},
    '{wsm_pkg::KindPattern, "a*c",     8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "abbbc",   8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "abd",     8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "*",       8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    ".hidden", 8'h00, 0,   "",    1'b0, 1'b1, Miss},
    '{wsm_pkg::KindName,    "x",       8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, ".*",      8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    ".hidden", 8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "a**",     8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "a",       8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "*ab*b",   8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "aabxb",   8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "a",       8'h00, 1,   "*",   1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "a",       8'h00, 1,   "zz",  1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "",        8'hFF, 2,   "*",   1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "",        8'hFF, 2,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "",        8'h01, 1,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "",        "a",   65,  "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "a",       8'h00, 0,   "",    1'b0, 1'b1, OverLimit},
    '{wsm_pkg::KindPattern, "*",       "a",   62,  "b",   1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "",        "a",   256, "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "",        "a",   257, "",    1'b0, 1'b1, OverLimit},
    '{wsm_pkg::KindPattern, "ab",      8'h00, 0,   "",    1'b1, 1'b0, Miss},
    '{wsm_pkg::KindName,    "ab",      8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindPattern, "c",       8'h00, 0,   "",    1'b0, 1'b0, Miss},
    '{wsm_pkg::KindName,    "abc",     8'h00, 0,   "",    1'b0, 1'b0, Miss}
  };

  wildcard_star_matcher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Greedy walk with backtracking to the most recent star.
  function automatic bit glob_walk();
    int pp;
    int np;
    int sp;
    int rp;
    bit seen;
    pp = 0;
    np = 0;
    sp = 0;
    rp = 0;
    seen = 1'b0;
    if (name_len > 0 && name_mem[0] == wsm_pkg::DotChar &&
        (pat_len == 0 || pat_mem[0] != wsm_pkg::DotChar)) begin
      return 1'b0;
    end
    while (np < name_len) begin
      if (pp < pat_len && pat_mem[pp] == wsm_pkg::StarChar) begin
        sp = pp;
        seen = 1'b1;
        pp++;
        rp = np;
      end else if (pp < pat_len && pat_mem[pp] == name_mem[np]) begin
        pp++;
        np++;
      end else if (seen) begin
        pp = sp + 1;
        rp++;
        np = rp;
      end else begin
        return 1'b0;
      end
    end
    while (pp < pat_len && pat_mem[pp] == wsm_pkg::StarChar) pp++;
    return pp == pat_len;
  endfunction

  function automatic void predict_verdict(input wsm_pkg::in_t item, output bit produced,
                                          output wsm_pkg::out_t verdict);
    produced = 1'b0;
    verdict = Miss;
    if (item.kind == wsm_pkg::KindPattern) begin
      if (pat_done) begin
        pat_len = 0;
        pat_ovf = 1'b0;
        pat_done = 1'b0;
      end
      if (pat_len < wsm_pkg::MaxPatternLen) begin
        pat_mem[pat_len] = item.char_value;
        pat_len++;
      end else begin
        pat_ovf = 1'b1;
      end
      if (item.last) pat_done = 1'b1;
    end else begin
      if (name_len < wsm_pkg::MaxNameLen) begin
        name_mem[name_len] = item.char_value;
        name_len++;
      end else begin
        name_ovf = 1'b1;
      end
      if (item.last) begin
        verdict.too_long = pat_ovf || name_ovf;
        verdict.matched = verdict.too_long ? 1'b0 : glob_walk();
        produced = 1'b1;
        name_len = 0;
        name_ovf = 1'b0;
      end
    end
  endfunction

  // Mostly letters that the patterns use, with dots, stars and any other byte now and then.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return "a";
    if (r < 55) return "b";
    if (r < 70) return "c";
    if (r < 80) return wsm_pkg::DotChar;
    if (r < 88) return wsm_pkg::StarChar;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_string(input logic kind, input logic [7:0] text[$], input bit open,
                             input bit pinned, input wsm_pkg::out_t pinned_verdict);
    wsm_pkg::in_t  item;
    bit            produced;
    wsm_pkg::out_t verdict;
    foreach (text[i]) begin
      item.kind = kind;
      item.char_value = text[i];
      item.last = (i == text.size() - 1) && !open;
      while ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i <= item;
      do @(posedge clk_i); while (in_stall_o);
      items_sent++;
      predict_verdict(item, produced, verdict);
      if (produced) expected_verdicts.push_back(pinned ? pinned_verdict : verdict);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    wsm_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with none expected, got matched %0b too_long %0b",
                 $time, out_data_o.matched, out_data_o.too_long);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data_o.matched !== want.matched) begin
          $display("%0t: matched expected %0b got %0b", $time, want.matched,
                   out_data_o.matched);
          mismatches++;
        end
        if (out_data_o.too_long !== want.too_long) begin
          $display("%0t: too_long expected %0b got %0b", $time, want.too_long,
                   out_data_o.too_long);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [7:0] text[$];
    logic [7:0] pat_hint[$];
    int         len;
    int         roll;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      text.delete();
      for (int i = 0; i < dir_rows[r].pre.len(); i++) text.push_back(dir_rows[r].pre[i]);
      repeat (dir_rows[r].nfill) text.push_back(dir_rows[r].fill);
      for (int i = 0; i < dir_rows[r].post.len(); i++) text.push_back(dir_rows[r].post[i]);
      send_string(dir_rows[r].kind, text, dir_rows[r].open, dir_rows[r].pinned,
                  dir_rows[r].verdict);
    end

    items_sent = 0;
    pat_hint = '{"a", wsm_pkg::StarChar, "b"};
    while (items_sent < RandBytes) begin
      case (items_sent * 4 / RandBytes)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      text.delete();
      roll = $urandom_range(99);
      if (roll < 14) begin
        len = ($urandom_range(99) < 2) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (len) text.push_back(pick_char());
        pat_hint = text;
        // An unterminated pattern lets the following names see a partial pattern.
        send_string(wsm_pkg::KindPattern, text, $urandom_range(99) < 5, 1'b0, Miss);
      end else begin
        if ($urandom_range(99) < 2) begin
          repeat ($urandom_range(250, 262)) text.push_back(pick_char());
        end else if (roll < 80) begin
          // Expand each star of the current pattern, then sometimes corrupt one byte.
          foreach (pat_hint[j]) begin
            if (pat_hint[j] == wsm_pkg::StarChar) begin
              repeat ($urandom_range(0, 3)) text.push_back(pick_char());
            end else begin
              text.push_back(pat_hint[j]);
            end
          end
          if (text.size() == 0) text.push_back(pick_char());
          if ($urandom_range(99) < 30) text[$urandom_range(text.size() - 1)] = pick_char();
        end else begin
          repeat ($urandom_range(1, 10)) text.push_back(pick_char());
        end
        send_string(wsm_pkg::KindName, text, 1'b0, 1'b0, Miss);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
